[hdl/nrmd_pkg.sv]
// Shared types and constants for the nearest-neighbour resampler with mono downmix.
// Used by nrmd_mean and nearest_resampler_mono_downmix; depends on nothing.
package nrmd_pkg;

  localparam int MAX_CHANNELS      = 8;
  localparam int MAX_BLOCK_DEF     = 4096;
  localparam int MAX_OUT_PER_FRAME = 8;

  localparam logic [19:0] STEP_MIN = 20'd8192;
  localparam logic [19:0] STEP_MAX = 20'd524288;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_COUNT    = 2'd0;
  localparam logic [1:0] CFG_STEP_RATIO       = 2'd1;
  localparam logic [1:0] CFG_FRAMES_PER_BLOCK = 2'd2;
  localparam logic [1:0] CFG_OUT_BLOCK_LEN    = 2'd3;

  localparam logic [3:0]  RST_CHANNEL_COUNT    = 4'd1;
  localparam logic [19:0] RST_STEP_RATIO       = 20'd65536;
  localparam logic [12:0] RST_FRAMES_PER_BLOCK = 13'd1024;
  localparam logic [12:0] RST_OUT_BLOCK_LEN    = 13'd1024;

  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_PAD   = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [15:0] chan0;
    logic signed [15:0] chan1;
    logic signed [15:0] chan2;
    logic signed [15:0] chan3;
    logic signed [15:0] chan4;
    logic signed [15:0] chan5;
    logic signed [15:0] chan6;
    logic signed [15:0] chan7;
  } nrmd_in_t;

  typedef struct packed {
    logic signed [15:0] mono_sample;
    logic               block_end;
  } nrmd_out_t;

  typedef struct packed {
    logic       start;
    logic [3:0] nch;
  } nrmd_mean_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] mean;
  } nrmd_mean_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEAN,
    ST_EMIT,
    ST_PAD
  } nrmd_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_SUM,
    MS_ABS,
    MS_DIV,
    MS_SIGN
  } nrmd_mstate_t;

endpackage

[hdl/nrmd_mean.sv]
// Channel mean unit: sums the used channels, then divides by the channel count
// with truncation toward zero, all on one shared add/subtract unit. Uses nrmd_pkg.
module nrmd_mean (
  input  logic                    clk,
  input  logic                    rst,
  input  nrmd_pkg::nrmd_mean_req_t req,
  input  nrmd_pkg::nrmd_in_t      frame,
  output nrmd_pkg::nrmd_mean_rsp_t rsp
);
  import nrmd_pkg::*;

  localparam int MAG_W = 19;

  nrmd_mstate_t       mstate, mstate_next;
  logic signed [15:0] chan_r [MAX_CHANNELS];
  logic [3:0]         nch;
  logic [2:0]         idx;
  logic signed [19:0] acc;
  logic [MAG_W-1:0]   dq;
  logic [2:0]         rem;
  logic [4:0]         bitcnt;
  logic               neg;
  logic               done;
  logic signed [15:0] mean;

  // shared add/subtract unit
  logic signed [19:0] add_a, add_b, add_y;
  logic               add_sub;
  logic [3:0]         trial_in;
  logic signed [15:0] cur_chan;

  assign add_y    = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign trial_in = {rem, dq[MAG_W-1]};
  assign cur_chan = chan_r[idx];
  assign rsp      = {done, mean};

  always_comb begin
    mstate_next = mstate;
    add_a       = '0;
    add_b       = '0;
    add_sub     = 1'b0;
    unique case (mstate)
      MS_IDLE: begin
        if (req.start) mstate_next = MS_SUM;
      end
      MS_SUM: begin
        add_a = acc;
        add_b = {{4{cur_chan[15]}}, cur_chan};
        if ({1'b0, idx} == nch - 4'd1) mstate_next = MS_ABS;
      end
      MS_ABS: begin
        add_sub = 1'b1;
        add_b   = acc;
        mstate_next = MS_DIV;
      end
      MS_DIV: begin
        add_sub = 1'b1;
        add_a   = 20'(trial_in);
        add_b   = 20'(nch);
        if (bitcnt == 5'(MAG_W - 1)) mstate_next = MS_SIGN;
      end
      MS_SIGN: begin
        add_sub = neg;
        add_b   = 20'(dq);
        mstate_next = MS_IDLE;
      end
      default: mstate_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= MS_IDLE;
      done   <= 1'b0;
    end else begin
      mstate <= mstate_next;
      done   <= (mstate == MS_SIGN);
    end
  end

  always_ff @(posedge clk) begin
    case (mstate)
      MS_IDLE: begin
        if (req.start) begin
          chan_r[0] <= frame.chan0;
          chan_r[1] <= frame.chan1;
          chan_r[2] <= frame.chan2;
          chan_r[3] <= frame.chan3;
          chan_r[4] <= frame.chan4;
          chan_r[5] <= frame.chan5;
          chan_r[6] <= frame.chan6;
          chan_r[7] <= frame.chan7;
          nch <= req.nch;
          acc <= '0;
          idx <= '0;
        end
      end
      MS_SUM: begin
        acc <= add_y;
        idx <= idx + 3'd1;
      end
      MS_ABS: begin
        // take the magnitude, remember the sign for the end
        neg    <= acc[19];
        dq     <= acc[19] ? add_y[MAG_W-1:0] : acc[MAG_W-1:0];
        rem    <= '0;
        bitcnt <= '0;
      end
      MS_DIV: begin
        // restoring step: keep the difference when it does not go negative
        if (!add_y[19]) begin
          rem <= add_y[2:0];
          dq  <= {dq[MAG_W-2:0], 1'b1};
        end else begin
          rem <= trial_in[2:0];
          dq  <= {dq[MAG_W-2:0], 1'b0};
        end
        bitcnt <= bitcnt + 5'd1;
      end
      MS_SIGN: begin
        mean <= add_y[15:0];
      end
      default: ;
    endcase
  end

endmodule

[hdl/nearest_resampler_mono_downmix.sv]
// Top level of the nearest-neighbour resampler with mono downmix: configuration,
// block/phase sequencer and output register. Uses nrmd_pkg and nrmd_mean.
//
//   channel  | direction | handshake              | payload
//   frame    | in        | frame_valid/frame_ready | nrmd_in_t  (action, chan0..chan7)
//   mono     | out       | mono_valid/mono_ready   | nrmd_out_t (mono_sample, block_end)
//   cfg      | in        | cfg_we                  | cfg_index, cfg_data
//
// A frame request computes the mean (serial sum, magnitude, 19-step restoring divide
// on the shared adder, sign, hand-over), then emits one result per cycle while the output
// register is free, and closes the frame. A pad request emits a zero sample if outputs
// are owed, else closes the block. frame_ready is high only while the sequencer idles;
// a result held in the output register does not block the next request, but a new
// result waits until the register frees. Synchronous reset, no clearing pass.
module nearest_resampler_mono_downmix #(
  parameter int MAX_BLOCK = nrmd_pkg::MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  output logic               frame_ready,
  input  nrmd_pkg::nrmd_in_t  frame,
  output logic               mono_valid,
  input  logic               mono_ready,
  output nrmd_pkg::nrmd_out_t mono,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  import nrmd_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int FR_W  = $clog2(MAX_BLOCK);
  localparam int PH_W  = CNT_W + 20;
  localparam int HI_W  = PH_W - 16;

  logic [3:0]  channel_count;
  logic [19:0] step_ratio;
  logic [12:0] frames_per_block;
  logic [12:0] out_block_len;

  logic [3:0]       nch_c;
  logic [19:0]      step_c;
  logic [CNT_W-1:0] fpb_c, len_c;

  nrmd_state_t      state, state_next;
  logic [PH_W-1:0]  phase_pos;
  logic [FR_W-1:0]  frame_pos;
  logic [CNT_W-1:0] out_pos;
  logic [3:0]       n_out;

  nrmd_mean_req_t mreq;
  nrmd_mean_rsp_t mrsp;

  logic             accept, slot_free, emit_ok, owed;
  logic             load, advance, restart, frame_step, n_clear;
  logic             last;
  logic signed [15:0] load_sample;
  logic [CNT_W-1:0] out_inc, frame_inc;

  // register decode
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= RST_CHANNEL_COUNT;
      step_ratio       <= RST_STEP_RATIO;
      frames_per_block <= RST_FRAMES_PER_BLOCK;
      out_block_len    <= RST_OUT_BLOCK_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT:    channel_count    <= cfg_data[3:0];
        CFG_STEP_RATIO:       step_ratio       <= cfg_data;
        CFG_FRAMES_PER_BLOCK: frames_per_block <= cfg_data[12:0];
        CFG_OUT_BLOCK_LEN:    out_block_len    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // saturate registers to their legal ranges
  always_comb begin
    if (channel_count == 4'd0)                      nch_c = 4'd1;
    else if (32'(channel_count) > 32'(MAX_CHANNELS)) nch_c = 4'(MAX_CHANNELS);
    else                                            nch_c = channel_count;

    if (step_ratio < STEP_MIN)      step_c = STEP_MIN;
    else if (step_ratio > STEP_MAX) step_c = STEP_MAX;
    else                            step_c = step_ratio;

    if (frames_per_block == 13'd0)                    fpb_c = CNT_W'(1);
    else if (32'(frames_per_block) > 32'(MAX_BLOCK)) fpb_c = CNT_W'(MAX_BLOCK);
    else                                             fpb_c = CNT_W'(frames_per_block);

    if (out_block_len == 13'd0)                    len_c = CNT_W'(1);
    else if (32'(out_block_len) > 32'(MAX_BLOCK)) len_c = CNT_W'(MAX_BLOCK);
    else                                          len_c = CNT_W'(out_block_len);
  end

  assign frame_ready = (state == ST_IDLE);
  assign accept      = frame_valid && frame_ready;
  assign slot_free   = !mono_valid || mono_ready;

  assign mreq.start = accept && (frame.action == ACT_FRAME);
  assign mreq.nch   = nch_c;

  nrmd_mean u_mean (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .frame (frame),
    .rsp   (mrsp)
  );

  assign out_inc   = out_pos + CNT_W'(1);
  assign frame_inc = CNT_W'(frame_pos) + CNT_W'(1);
  assign owed      = out_pos < len_c;
  assign emit_ok   = owed && (32'(n_out) < 32'(MAX_OUT_PER_FRAME))
                     && (phase_pos[PH_W-1:16] <= HI_W'(frame_pos));
  assign last      = (out_inc == len_c);

  always_comb begin
    state_next  = state;
    load        = 1'b0;
    advance     = 1'b0;
    restart     = 1'b0;
    frame_step  = 1'b0;
    n_clear     = 1'b0;
    load_sample = mrsp.mean;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = (frame.action == ACT_PAD) ? ST_PAD : ST_MEAN;
      end
      ST_MEAN: begin
        if (mrsp.done) begin
          n_clear    = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          if (slot_free) begin
            load    = 1'b1;
            advance = 1'b1;
          end
        end else begin
          // frame finished: count it, close the block when its frames run out
          if (frame_inc >= fpb_c) restart = 1'b1;
          else                    frame_step = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        load_sample = '0;
        if (owed) begin
          if (slot_free) begin
            load    = 1'b1;
            advance = 1'b1;
            restart = last;
            state_next = ST_IDLE;
          end
        end else begin
          restart    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase_pos <= '0;
      frame_pos <= '0;
      out_pos   <= '0;
      n_out     <= '0;
    end else begin
      state <= state_next;
      if (n_clear) n_out <= '0;
      else if (advance) n_out <= n_out + 4'd1;
      if (restart) begin
        phase_pos <= '0;
        frame_pos <= '0;
        out_pos   <= '0;
      end else begin
        if (advance) begin
          out_pos   <= out_inc;
          phase_pos <= phase_pos + PH_W'(step_c);
        end
        if (frame_step) frame_pos <= FR_W'(frame_inc);
      end
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mono_valid <= 1'b0;
    end else if (load) begin
      mono_valid <= 1'b1;
    end else if (mono_ready) begin
      mono_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mono.mono_sample <= load_sample;
      mono.block_end   <= last;
    end
  end

endmodule

[bench/tb_nearest_resampler_mono_downmix.sv]
// Self-checking bench for nearest_resampler_mono_downmix: drives frame and pad requests
// under random idling, predicts each mono sample and checks it in order.
// Depends on nrmd_pkg and the nearest_resampler_mono_downmix RTL only.
module tb_nearest_resampler_mono_downmix;
  timeunit 1ns;
  timeprecision 1ps;
  import nrmd_pkg::*;

  localparam int MAX_BLOCK_LEN = MAX_BLOCK_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;

  // Predicts the mono stream from accepted requests and checks what comes out.
  class mono_scoreboard;
    logic [3:0]        reg_channels;
    logic [19:0]       reg_step;
    logic [12:0]       reg_frames;
    logic [12:0]       reg_out_len;
    longint unsigned   phase_q16;
    int unsigned       frame_idx;
    int unsigned       out_idx;
    nrmd_out_t         owed_samples[$];
    int                mismatches;

    function new();
      reg_channels = RST_CHANNEL_COUNT;
      reg_step     = RST_STEP_RATIO;
      reg_frames   = RST_FRAMES_PER_BLOCK;
      reg_out_len  = RST_OUT_BLOCK_LEN;
      mismatches   = 0;
      restart_block();
    endfunction

    function void restart_block();
      phase_q16 = 0;
      frame_idx = 0;
      out_idx   = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] data);
      case (idx)
        CFG_CHANNEL_COUNT:    reg_channels = data[3:0];
        CFG_STEP_RATIO:       reg_step     = data;
        CFG_FRAMES_PER_BLOCK: reg_frames   = data[12:0];
        CFG_OUT_BLOCK_LEN:    reg_out_len  = data[12:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return owed_samples.size();
    endfunction

    function void note_request(nrmd_in_t req);
      int unsigned        nch;
      int unsigned        step;
      int unsigned        fpb;
      int unsigned        len;
      logic signed [15:0] lanes [MAX_CHANNELS];
      int                 sum;
      int                 mean;
      int                 burst;
      int                 c;
      nrmd_out_t          s;
      nch  = clip(reg_channels, 1, MAX_CHANNELS);
      step = clip(reg_step, STEP_MIN, STEP_MAX);
      fpb  = clip(reg_frames, 1, MAX_BLOCK_LEN);
      len  = clip(reg_out_len, 1, MAX_BLOCK_LEN);
      if (req.action == ACT_PAD) begin
        if (out_idx < len) begin
          s.mono_sample = '0;
          s.block_end   = (out_idx + 1 == len);
          owed_samples.insert(owed_samples.size(), s);
          out_idx++;
          phase_q16 += step;
          if (out_idx >= len) restart_block();
        end else begin
          // outputs already complete: the pad only closes the block
          restart_block();
        end
        return;
      end
      lanes = '{req.chan0, req.chan1, req.chan2, req.chan3,
                req.chan4, req.chan5, req.chan6, req.chan7};
      sum = 0;
      for (c = 0; c < nch; c++) sum += lanes[c];
      mean  = sum / int'(nch);
      burst = 0;
      while (out_idx < len && burst < MAX_OUT_PER_FRAME && (phase_q16 >> 16) <= frame_idx) begin
        s.mono_sample = 16'(mean);
        s.block_end   = (out_idx + 1 == len);
        owed_samples.insert(owed_samples.size(), s);
        burst++;
        out_idx++;
        phase_q16 += step;
      end
      frame_idx++;
      if (frame_idx >= fpb) restart_block();
    endfunction

    function void check_sample(nrmd_out_t got);
      nrmd_out_t want;
      if (owed_samples.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected sample, expected none, actual %0d block_end %0b",
                 $time, got.mono_sample, got.block_end);
        return;
      end
      want = owed_samples[0];
      owed_samples.delete(0);
      if (got.mono_sample !== want.mono_sample) begin
        mismatches++;
        $display("%0t: mono_sample expected %0d actual %0d",
                 $time, want.mono_sample, got.mono_sample);
      end
      if (got.block_end !== want.block_end) begin
        mismatches++;
        $display("%0t: block_end expected %0b actual %0b",
                 $time, want.block_end, got.block_end);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        frame_valid = 1'b0;
  logic        frame_ready;
  nrmd_in_t    frame = '0;
  logic        mono_valid;
  logic        mono_ready = 1'b0;
  nrmd_out_t   mono;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_CHANNEL_COUNT;
  logic [19:0] cfg_data = '0;

  bit sender_idles = 1'b1;
  bit mono_idles   = 1'b1;
  bit hold_mono    = 1'b0;

  mono_scoreboard sb = new();

  nearest_resampler_mono_downmix u_dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .mono_valid  (mono_valid),
    .mono_ready  (mono_ready),
    .mono        (mono),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && frame_valid && frame_ready) sb.note_request(frame);
    if (!rst && mono_valid && mono_ready) sb.check_sample(mono);
  end

  // Receiver: random stalls, one long hold-off on request, none once calm.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_mono) begin
        mono_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_mono = 1'b0;
      end else if (mono_idles && $urandom_range(0, 2) == 0) begin
        mono_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      mono_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [15:0] random_lane();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic nrmd_in_t random_request(bit pad);
    nrmd_in_t req;
    req.action = pad ? ACT_PAD : ACT_FRAME;
    req.chan0  = random_lane();
    req.chan1  = random_lane();
    req.chan2  = random_lane();
    req.chan3  = random_lane();
    req.chan4  = random_lane();
    req.chan5  = random_lane();
    req.chan6  = random_lane();
    req.chan7  = random_lane();
    return req;
  endfunction

  function automatic nrmd_in_t uniform_frame(logic signed [15:0] v);
    nrmd_in_t req;
    req = '{action: ACT_FRAME, chan0: v, chan1: v, chan2: v, chan3: v,
            chan4: v, chan5: v, chan6: v, chan7: v};
    return req;
  endfunction

  // Offer one request and hold it until accepted.
  task automatic send_request(nrmd_in_t req);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= req;
    @(posedge clk);
    while (!frame_ready) @(posedge clk);
  endtask

  // Drain outstanding samples, then give the sequencer time to go idle.
  task automatic settle();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0 || !frame_ready || mono_valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [19:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic write_settings(logic [3:0] ch, logic [19:0] step,
                                logic [12:0] fpb, logic [12:0] len);
    put_reg(CFG_CHANNEL_COUNT, 20'(ch));
    put_reg(CFG_STEP_RATIO, step);
    put_reg(CFG_FRAMES_PER_BLOCK, 20'(fpb));
    put_reg(CFG_OUT_BLOCK_LEN, 20'(len));
    cfg_we <= 1'b0;
  endtask

  task automatic write_random_settings();
    logic [3:0]  ch;
    logic [19:0] step;
    logic [12:0] fpb;
    logic [12:0] len;
    ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
    case ($urandom_range(0, 9))
      0: step = STEP_MIN;
      1: step = STEP_MAX;
      2: step = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(0, 8191))
                                             : 20'($urandom_range(524289, 1048575));
      default: step = 20'($urandom_range(8192, 196608));
    endcase
    case ($urandom_range(0, 11))
      0: fpb = 13'(MAX_BLOCK_LEN);
      1: fpb = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(4097, 8191));
      default: fpb = 13'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 11))
      0: len = 13'(MAX_BLOCK_LEN);
      1: len = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(4097, 8191));
      default: len = 13'($urandom_range(1, 24));
    endcase
    write_settings(ch, step, fpb, len);
  endtask

  initial begin
    nrmd_in_t req;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one sample per frame, pad while outputs are owed
    req = random_request(1'b0);
    req.chan0 = 16'sh7fff;
    send_request(req);
    req.chan0 = 16'sh8000;
    send_request(req);
    send_request(random_request(1'b1));

    // shrink the block mid-way, then exhaust frames with outputs still owed
    settle();
    write_settings(4'd8, 20'd8192, 13'd1, 13'd12);
    send_request(uniform_frame(16'sh7fff));
    send_request(uniform_frame(16'sh8000));

    // eight samples from one frame, block complete, further frames dropped
    settle();
    write_settings(4'd8, 20'd8192, 13'd4, 13'd12);
    repeat (4) send_request(random_request(1'b0));
    send_request(random_request(1'b1));

    // odd channel count truncates toward zero; a pad supplies the last sample and closes the block
    settle();
    write_settings(4'd3, 20'd524288, 13'd20, 13'd2);
    req = random_request(1'b0);
    req.chan0 = -16'sd1;
    req.chan1 = 16'sd0;
    req.chan2 = 16'sd0;
    send_request(req);
    send_request(random_request(1'b0));
    send_request(random_request(1'b1));
    req.chan0 = -16'sd5;
    req.chan1 = -16'sd5;
    req.chan2 = 16'sd3;
    send_request(req);
    send_request(random_request(1'b1));

    // registers below range saturate; the block length is above range and saturates too
    settle();
    write_settings(4'd0, 20'd0, 13'd0, 13'd8191);
    req = random_request(1'b0);
    req.chan0 = 16'sh8000;
    send_request(req);
    req.chan0 = 16'sh7fff;
    send_request(req);

    // registers above range saturate; the block length is below range and saturates too
    settle();
    write_settings(4'd15, 20'hfffff, 13'd5000, 13'd0);
    send_request(uniform_frame(16'sh7fff));
    send_request(random_request(1'b1));
    req = '{action: ACT_FRAME, chan0: 16'sh8000, chan1: 16'sh7fff, chan2: 16'sh8000,
            chan3: 16'sh7fff, chan4: 16'sh8000, chan5: 16'sh7fff, chan6: 16'sh8000,
            chan7: 16'sh7fff};
    send_request(req);

    // hold the receiver off while requests keep coming, so the input stalls
    settle();
    write_settings(4'd4, 20'd32768, 13'd64, 13'd64);
    sender_idles = 1'b0;
    hold_mono    = 1'b1;
    repeat (30) send_request(random_request(1'b0));
    sender_idles = 1'b1;

    for (int p = 0; p < 15; p++) begin
      settle();
      if (p >= 12) begin
        sender_idles = 1'b0;
        mono_idles   = 1'b0;
      end
      write_random_settings();
      repeat (22) send_request(random_request($urandom_range(0, 5) == 0));
    end

    frame_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 20000 && sb.outstanding() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d samples expected, actual none", $time, sb.outstanding());
    end
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
